// ===== src/gsab_pkg.sv =====
package gsab_pkg;

	localparam logic [1:0] REG_BG_RED       = 2'd0;
	localparam logic [1:0] REG_BG_GREEN     = 2'd1;
	localparam logic [1:0] REG_BG_BLUE      = 2'd2;
	localparam logic [1:0] REG_DEPTH_ENABLE = 2'd3;

	localparam logic [16:0] T_ONE         = 17'd65536;
	// transmittance * 10000 < 1.0 in q1.16
	localparam logic [16:0] T_DONE        = 17'd7;
	localparam logic [16:0] ALPHA_CAP     = 17'd64881;
	// alpha * 255 < 1.0 below this
	localparam logic [16:0] ALPHA_MIN     = 17'd258;
	localparam logic [17:0] ACC_COLOR_MAX = 18'h3FFFF;
	localparam logic [19:0] ACC_DEPTH_MAX = 20'hFFFFF;
	localparam logic [15:0] OUT_COLOR_MAX = 16'hFFFF;
	localparam logic [18:0] OUT_DEPTH_MAX = 19'h7FFFF;
	localparam logic [4:0]  DIV_LAST      = 5'd28;

	typedef struct packed {
		logic               in_box;
		logic               last;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [19:0] conic_a;
		logic signed [19:0] conic_b;
		logic signed [19:0] conic_c;
		logic [15:0]        opacity;
		logic [47:0]        color_rgb;
		logic [23:0]        depth;
	} splat_cmd_t;

	typedef struct packed {
		logic [15:0] bg_red;
		logic [15:0] bg_green;
		logic [15:0] bg_blue;
		logic        depth_enable;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic idle;
	} back_stat_t;

	// exp(-x) in q.32 by a series up to the twelfth power, x in q.32
	function automatic logic [63:0] taylor_sum(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] sum;
		term = 64'd1 << 32;
		sum  = 64'd1 << 32;
		term = ((term * x) >> 32) / 1;  sum = sum - term;
		term = ((term * x) >> 32) / 2;  sum = sum + term;
		term = ((term * x) >> 32) / 3;  sum = sum - term;
		term = ((term * x) >> 32) / 4;  sum = sum + term;
		term = ((term * x) >> 32) / 5;  sum = sum - term;
		term = ((term * x) >> 32) / 6;  sum = sum + term;
		term = ((term * x) >> 32) / 7;  sum = sum - term;
		term = ((term * x) >> 32) / 8;  sum = sum + term;
		term = ((term * x) >> 32) / 9;  sum = sum - term;
		term = ((term * x) >> 32) / 10; sum = sum + term;
		term = ((term * x) >> 32) / 11; sum = sum - term;
		term = ((term * x) >> 32) / 12; sum = sum + term;
		return sum;
	endfunction

	function automatic logic [16:0] exp_entry(input int unsigned i, input logic [63:0] s);
		logic [63:0] e;
		logic [63:0] r;
		e = 64'd1 << 32;
		for (int unsigned k = 0; k < i; k++) begin
			e = (e * s + (64'd1 << 31)) >> 32;
		end
		r = (e + 64'd32768) >> 16;
		return r[16:0];
	endfunction

	function automatic logic [31:0] rnd16(input logic signed [47:0] p);
		logic [47:0] s;
		s = p + 48'd32768;
		return s[47:16];
	endfunction

endpackage

// ===== src/gsab_if.sv =====
interface gsab_splat_if;
	logic               valid;
	logic               ready;
	logic [11:0]        pix_x;
	logic [11:0]        pix_y;
	logic signed [17:0] mean_x;
	logic signed [17:0] mean_y;
	logic [11:0]        radius;
	logic signed [19:0] conic_a;
	logic signed [19:0] conic_b;
	logic signed [19:0] conic_c;
	logic [15:0]        opacity;
	logic [47:0]        color_rgb;
	logic [23:0]        depth;
	logic               last;

	modport source(output valid, pix_x, pix_y, mean_x, mean_y, radius, conic_a, conic_b,
		conic_c, opacity, color_rgb, depth, last, input ready);
	modport sink(input valid, pix_x, pix_y, mean_x, mean_y, radius, conic_a, conic_b,
		conic_c, opacity, color_rgb, depth, last, output ready);
endinterface

interface gsab_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic [18:0] out_inv_depth;

	modport source(output valid, out_red, out_green, out_blue, out_inv_depth, input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_inv_depth, output ready);
endinterface

// ===== src/gaussian_splat_alpha_blend.sv =====
// flow: the front register stage and the queue, then the back sequencer, which runs the
// 29-step divider for a blended splat when inverse depth is on, but not for a skipped or
// ignored splat; a last item adds the background blend and output load
// throughput: one item per back sequence, set by the single shared 30x18 multiplier
// and the bit-serial divider; a 2-entry queue lets the front keep accepting meanwhile
// reset: arst_n clears the pixel state to transmittance one, background to black, depth on
module gaussian_splat_alpha_blend
	import gsab_pkg::*;
#(
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	gsab_splat_if.sink   splat_in,
	gsab_pixel_if.source pixel_out,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cfg_t       cfg_q;
	logic       push_valid;
	logic       push_ready;
	splat_cmd_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	splat_cmd_t pop_data;
	fifo_stat_t qstat;
	back_stat_t bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bg_red       <= '0;
			cfg_q.bg_green     <= '0;
			cfg_q.bg_blue      <= '0;
			cfg_q.depth_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BG_RED:       cfg_q.bg_red       <= cfg_data;
				REG_BG_GREEN:     cfg_q.bg_green     <= cfg_data;
				REG_BG_BLUE:      cfg_q.bg_blue      <= cfg_data;
				REG_DEPTH_ENABLE: cfg_q.depth_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gsab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.splat_in   (splat_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	gsab_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.stat       (qstat)
	);

	gsab_back #(
		.EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pixel_out (pixel_out),
		.stat      (bstat)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty at once");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel_out.valid) |-> $past(!bstat.idle))
		else $error("result appeared without a finishing pixel");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && bstat.idle) |=> !bstat.idle)
		else $error("sequencer idle with a request waiting");

endmodule

// ===== src/gsab_front.sv =====
module gsab_front
	import gsab_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	gsab_splat_if.sink   splat_in,
	output logic         push_valid,
	input  logic         push_ready,
	output splat_cmd_t   push_data
);

	logic               v_s1;
	splat_cmd_t         cmd_s1;
	logic signed [18:0] dx;
	logic signed [18:0] dy;
	logic signed [18:0] box;
	logic               in_box;

	assign splat_in.ready = !v_s1 || push_ready;

	always_comb begin
		dx = 19'(splat_in.mean_x) - $signed({3'b000, splat_in.pix_x, 4'b0000});
		dy = 19'(splat_in.mean_y) - $signed({3'b000, splat_in.pix_y, 4'b0000});
		box = $signed({3'b000, splat_in.radius, 4'b0000});
		in_box = (dx <= box) && (dx >= -box) && (dy <= box) && (dy >= -box);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (splat_in.valid && splat_in.ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (splat_in.valid && splat_in.ready) begin
			cmd_s1.in_box    <= in_box;
			cmd_s1.last      <= splat_in.last;
			// only meaningful inside the box, where they fit 18 bits
			cmd_s1.dx        <= dx[17:0];
			cmd_s1.dy        <= dy[17:0];
			cmd_s1.conic_a   <= splat_in.conic_a;
			cmd_s1.conic_b   <= splat_in.conic_b;
			cmd_s1.conic_c   <= splat_in.conic_c;
			cmd_s1.opacity   <= splat_in.opacity;
			cmd_s1.color_rgb <= splat_in.color_rgb;
			cmd_s1.depth     <= splat_in.depth;
		end
	end

	assign push_valid = v_s1;
	assign push_data  = cmd_s1;

endmodule

// ===== src/gsab_queue.sv =====
module gsab_queue
	import gsab_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  splat_cmd_t push_data,
	output logic       pop_valid,
	input  logic       pop_ready,
	output splat_cmd_t pop_data,
	output fifo_stat_t stat
);

	splat_cmd_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== src/gsab_back.sv =====
module gsab_back
	import gsab_pkg::*;
#(
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  splat_cmd_t   pop_data,
	gsab_pixel_if.source pixel_out,
	output back_stat_t   stat
);

	localparam int          IDX_W    = $clog2(EXP_TABLE_ENTRIES);
	localparam logic [63:0] EXP_X    = (64'd8 << 32) / EXP_TABLE_ENTRIES;
	localparam logic [63:0] EXP_STEP = taylor_sum(EXP_X);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_QMUL  = 4'd1;
	localparam logic [3:0] ST_QCHK  = 4'd2;
	localparam logic [3:0] ST_IDX   = 4'd3;
	localparam logic [3:0] ST_EXP   = 4'd4;
	localparam logic [3:0] ST_ALPHA = 4'd5;
	localparam logic [3:0] ST_W     = 4'd6;
	localparam logic [3:0] ST_COL   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_DMUL  = 4'd9;
	localparam logic [3:0] ST_TUPD  = 4'd10;
	localparam logic [3:0] ST_LAST  = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	logic [16:0] exp_rom [EXP_TABLE_ENTRIES];

	for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_rom
		assign exp_rom[g] = exp_entry(g, EXP_STEP);
	end

	logic [3:0]         state_q;
	logic [4:0]         cnt_q;
	splat_cmd_t         cur_q;
	logic signed [55:0] qsum_q;
	logic signed [37:0] t_q;
	logic [IDX_W-1:0]   idx_q;
	logic [16:0]        e_q;
	logic [15:0]        alpha_q;
	logic [15:0]        w_q;
	logic [16:0]        trans_q;
	logic [17:0]        acc_r_q;
	logic [17:0]        acc_g_q;
	logic [17:0]        acc_b_q;
	logic [19:0]        acc_d_q;
	logic               done_q;
	logic [23:0]        rem_q;
	logic [28:0]        inv_q;
	logic [15:0]        fin_r_q;
	logic [15:0]        fin_g_q;
	logic [15:0]        fin_b_q;
	logic               out_valid_q;
	logic [15:0]        out_r_q;
	logic [15:0]        out_g_q;
	logic [15:0]        out_b_q;
	logic [18:0]        out_d_q;

	logic signed [29:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [47:0] prod;
	logic [31:0]        prod_rnd;
	logic signed [55:0] q_add;
	logic [16:0]        alpha_cap;
	logic [17:0]        acc_sel;
	logic [18:0]        col_sum;
	logic [29:0]        dep_sum;
	logic [18:0]        fin_sum;
	logic [16:0]        trans_new;
	logic [23:0]        divisor;
	logic [24:0]        rem_shift;
	logic               qbit;
	logic [23:0]        rem_next;

	// one shared multiplier, operands picked by the sequencer
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_QMUL: begin
				unique case (cnt_q)
					5'd0: begin mul_a = 30'(cur_q.conic_a); mul_b = cur_q.dx; end
					5'd3: begin mul_a = 30'(cur_q.conic_c); mul_b = cur_q.dy; end
					5'd6: begin mul_a = 30'(cur_q.conic_b); mul_b = cur_q.dx; end
					5'd1, 5'd7: begin mul_a = {1'b0, t_q[28:0]}; mul_b = (cnt_q == 5'd1) ? cur_q.dx : cur_q.dy; end
					5'd4: begin mul_a = {1'b0, t_q[28:0]}; mul_b = cur_q.dy; end
					5'd2: begin mul_a = 30'($signed(t_q[37:29])); mul_b = cur_q.dx; end
					5'd5, 5'd8: begin mul_a = 30'($signed(t_q[37:29])); mul_b = cur_q.dy; end
					default: ;
				endcase
			end
			ST_IDX: begin
				mul_a = {2'b00, qsum_q[27:0]};
				mul_b = 18'(EXP_TABLE_ENTRIES);
			end
			ST_ALPHA: begin
				mul_a = {14'd0, cur_q.opacity};
				mul_b = {1'b0, e_q};
			end
			ST_W: begin
				mul_a = {14'd0, alpha_q};
				mul_b = {1'b0, trans_q};
			end
			ST_COL: begin
				unique case (cnt_q)
					5'd0:    mul_a = {14'd0, cur_q.color_rgb[47:32]};
					5'd1:    mul_a = {14'd0, cur_q.color_rgb[31:16]};
					default: mul_a = {14'd0, cur_q.color_rgb[15:0]};
				endcase
				mul_b = {2'b00, w_q};
			end
			ST_DMUL: begin
				mul_a = {1'b0, inv_q};
				mul_b = {2'b00, w_q};
			end
			ST_FIN: begin
				mul_a = {13'd0, trans_q};
				unique case (cnt_q)
					5'd0:    mul_b = {2'b00, cfg.bg_red};
					5'd1:    mul_b = {2'b00, cfg.bg_green};
					default: mul_b = {2'b00, cfg.bg_blue};
				endcase
			end
			default: ;
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_rnd = rnd16(prod);

	always_comb begin
		unique case (cnt_q)
			5'd2, 5'd5: q_add = 56'(prod) <<< 29;
			5'd7:       q_add = 56'(prod) <<< 1;
			5'd8:       q_add = 56'(prod) <<< 30;
			default:    q_add = 56'(prod);
		endcase
	end

	always_comb begin
		alpha_cap = (prod_rnd[16:0] > ALPHA_CAP) ? ALPHA_CAP : prod_rnd[16:0];
		unique case (cnt_q)
			5'd0:    acc_sel = acc_r_q;
			5'd1:    acc_sel = acc_g_q;
			default: acc_sel = acc_b_q;
		endcase
		col_sum   = {1'b0, acc_sel} + {2'b00, prod_rnd[16:0]};
		dep_sum   = {10'd0, acc_d_q} + {1'b0, prod_rnd[28:0]};
		fin_sum   = {1'b0, acc_sel} + {2'b00, prod_rnd[16:0]};
		trans_new = trans_q - {1'b0, w_q};
		// restoring divide of 2^28 by depth, one quotient bit a cycle
		divisor   = (cur_q.depth == 24'd0) ? 24'd1 : cur_q.depth;
		rem_shift = {rem_q, (cnt_q == 5'd0)};
		qbit      = (rem_shift >= {1'b0, divisor});
		rem_next  = qbit ? 24'(rem_shift - {1'b0, divisor}) : rem_shift[23:0];
	end

	assign pop_ready = (state_q == ST_IDLE);
	assign stat.idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			trans_q     <= T_ONE;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
			acc_d_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || pixel_out.ready)) out_valid_q <= 1'b1;
			else if (pixel_out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop_valid) begin
						if (done_q || !pop_data.in_box) state_q <= ST_LAST;
						else state_q <= ST_QMUL;
					end
				end
				ST_QMUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8) state_q <= ST_QCHK;
				end
				ST_QCHK: begin
					// power above zero or beyond the table range
					if (qsum_q[55] || (|qsum_q[54:28])) state_q <= ST_LAST;
					else state_q <= ST_IDX;
				end
				ST_IDX:   state_q <= ST_EXP;
				ST_EXP:   state_q <= ST_ALPHA;
				ST_ALPHA: begin
					if (alpha_cap < ALPHA_MIN) state_q <= ST_LAST;
					else state_q <= ST_W;
				end
				ST_W: begin
					cnt_q   <= '0;
					state_q <= ST_COL;
				end
				ST_COL: begin
					unique case (cnt_q)
						5'd0:    acc_r_q <= col_sum[18] ? ACC_COLOR_MAX : col_sum[17:0];
						5'd1:    acc_g_q <= col_sum[18] ? ACC_COLOR_MAX : col_sum[17:0];
						default: acc_b_q <= col_sum[18] ? ACC_COLOR_MAX : col_sum[17:0];
					endcase
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= cfg.depth_enable ? ST_DIV : ST_TUPD;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					acc_d_q <= (|dep_sum[29:20]) ? ACC_DEPTH_MAX : dep_sum[19:0];
					state_q <= ST_TUPD;
				end
				ST_TUPD: begin
					trans_q <= trans_new;
					if (trans_new < T_DONE) done_q <= 1'b1;
					state_q <= ST_LAST;
				end
				ST_LAST: begin
					cnt_q   <= '0;
					state_q <= cur_q.last ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || pixel_out.ready) begin
						trans_q     <= T_ONE;
						acc_r_q     <= '0;
						acc_g_q     <= '0;
						acc_b_q     <= '0;
						acc_d_q     <= '0;
						done_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			cur_q  <= pop_data;
			qsum_q <= '0;
		end
		if (state_q == ST_QMUL) begin
			if (cnt_q == 5'd0 || cnt_q == 5'd3 || cnt_q == 5'd6) t_q <= prod[37:0];
			else qsum_q <= qsum_q + q_add;
		end
		if (state_q == ST_IDX) idx_q <= prod[28 +: IDX_W];
		if (state_q == ST_EXP) e_q <= exp_rom[idx_q];
		if (state_q == ST_ALPHA) alpha_q <= alpha_cap[15:0];
		if (state_q == ST_W) w_q <= prod_rnd[15:0];
		if (state_q == ST_COL) rem_q <= '0;
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			inv_q <= {inv_q[27:0], qbit};
		end
		if (state_q == ST_FIN) begin
			unique case (cnt_q)
				5'd0:    fin_r_q <= (|fin_sum[18:16]) ? OUT_COLOR_MAX : fin_sum[15:0];
				5'd1:    fin_g_q <= (|fin_sum[18:16]) ? OUT_COLOR_MAX : fin_sum[15:0];
				default: fin_b_q <= (|fin_sum[18:16]) ? OUT_COLOR_MAX : fin_sum[15:0];
			endcase
		end
		if (state_q == ST_OUT && (!out_valid_q || pixel_out.ready)) begin
			out_r_q <= fin_r_q;
			out_g_q <= fin_g_q;
			out_b_q <= fin_b_q;
			out_d_q <= (acc_d_q > {1'b0, OUT_DEPTH_MAX}) ? OUT_DEPTH_MAX : acc_d_q[18:0];
		end
	end

	assign pixel_out.valid         = out_valid_q;
	assign pixel_out.out_red       = out_r_q;
	assign pixel_out.out_green     = out_g_q;
	assign pixel_out.out_blue      = out_b_q;
	assign pixel_out.out_inv_depth = out_d_q;

endmodule

// ===== sim/gsab_tb_if.sv =====
`timescale 1ns / 1ps

// the block's interfaces come from the rtl; this file holds a helper record only
package gsab_tb_pkg;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [18:0] inv_depth;
	} pixel_result_t;

endpackage

// ===== sim/gsab_checker.sv =====
`timescale 1ns / 1ps

module gsab_checker
	import gsab_pkg::*;
	import gsab_tb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	gsab_splat_if         splat_in,
	gsab_pixel_if         pixel_out,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output int            fail_count,
	output int            pending,
	output int            pixels_seen
);

	localparam int TAB_N = 256;

	longint unsigned exp_lut [TAB_N];
	pixel_result_t   pixel_queue [$];

	logic [15:0] bg_r, bg_g, bg_b;
	logic        depth_on;
	longint unsigned trans, acc_r, acc_g, acc_b, acc_d;
	bit          done;

	initial begin
		longint unsigned x, s, term, e;
		x = (64'd8 << 32) / TAB_N;
		s = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * x) >> 32) / k;
			if (k & 1) s = s - term; else s = s + term;
		end
		e = 64'd1 << 32;
		for (int i = 0; i < TAB_N; i++) begin
			exp_lut[i] = (e + 32768) >> 16;
			e = (e * s + (64'd1 << 31)) >> 32;
		end
	end

	function automatic longint unsigned sat(longint unsigned v, longint unsigned m);
		return v > m ? m : v;
	endfunction

	function automatic longint unsigned rnd_mul(longint unsigned a, longint unsigned b);
		return (a * b + 32768) >> 16;
	endfunction

	task automatic clear_pixel();
		trans = 65536;
		acc_r = 0; acc_g = 0; acc_b = 0; acc_d = 0;
		done = 0;
	endtask

	task automatic blend_splat();
		longint signed dx, dy, box, a, b, c, q;
		longint unsigned alpha, w, idx, inv, dep;
		dx = longint'(splat_in.mean_x) - longint'({splat_in.pix_x, 4'd0});
		dy = longint'(splat_in.mean_y) - longint'({splat_in.pix_y, 4'd0});
		box = longint'({splat_in.radius, 4'd0});
		a = splat_in.conic_a;
		b = splat_in.conic_b;
		c = splat_in.conic_c;
		if (dx > box || -dx > box || dy > box || -dy > box) return;
		q = a * dx * dx + c * dy * dy + 2 * b * dx * dy;
		if (q < 0 || q >= (64'sd1 <<< 28)) return;
		idx = ($unsigned(q) * TAB_N) >> 28;
		if (idx >= TAB_N) idx = TAB_N - 1;
		alpha = rnd_mul(splat_in.opacity, exp_lut[idx]);
		if (alpha > ALPHA_CAP) alpha = ALPHA_CAP;
		if (alpha * 255 < 65536) return;
		w = rnd_mul(alpha, trans);
		acc_r = sat(acc_r + rnd_mul(splat_in.color_rgb[47:32], w), ACC_COLOR_MAX);
		acc_g = sat(acc_g + rnd_mul(splat_in.color_rgb[31:16], w), ACC_COLOR_MAX);
		acc_b = sat(acc_b + rnd_mul(splat_in.color_rgb[15:0], w), ACC_COLOR_MAX);
		if (depth_on) begin
			dep = splat_in.depth == 0 ? 1 : splat_in.depth;
			inv = (64'd1 << 28) / dep;
			acc_d = sat(acc_d + rnd_mul(inv, w), ACC_DEPTH_MAX);
		end
		trans = trans - w;
		if (trans * 10000 < 65536) done = 1;
	endtask

	function automatic logic [15:0] final_chan(longint unsigned acc, logic [15:0] bg);
		return 16'(sat(acc + rnd_mul(trans, bg), OUT_COLOR_MAX));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want, got;
		if (!arst_n) begin
			bg_r <= '0; bg_g <= '0; bg_b <= '0;
			depth_on <= 1'b1;
			clear_pixel();
			fail_count <= 0;
			pixels_seen <= 0;
			pending <= 0;
			pixel_queue.delete();
		end else begin
			if (splat_in.valid && splat_in.ready) begin
				if (!done) blend_splat();
				if (splat_in.last) begin
					want.red = final_chan(acc_r, bg_r);
					want.green = final_chan(acc_g, bg_g);
					want.blue = final_chan(acc_b, bg_b);
					want.inv_depth = 19'(sat(acc_d, OUT_DEPTH_MAX));
					pixel_queue = {pixel_queue, want};
					clear_pixel();
				end
			end
			if (pixel_out.valid && pixel_out.ready) begin
				got.red = pixel_out.out_red;
				got.green = pixel_out.out_green;
				got.blue = pixel_out.out_blue;
				got.inv_depth = pixel_out.out_inv_depth;
				pixels_seen <= pixels_seen + 1;
				if (pixel_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected pixel r=%0d g=%0d b=%0d d=%0d",
							got.red, got.green, got.blue, got.inv_depth);
					fail_count <= fail_count + 1;
				end else begin
					want = pixel_queue.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("pixel mismatch exp r=%0d g=%0d b=%0d d=%0d got r=%0d g=%0d b=%0d d=%0d",
								want.red, want.green, want.blue, want.inv_depth,
								got.red, got.green, got.blue, got.inv_depth);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= pixel_queue.size();
			// written while idle, so ordering against splats does not matter
			if (cfg_we) begin
				case (cfg_index)
					REG_BG_RED: bg_r <= cfg_data;
					REG_BG_GREEN: bg_g <= cfg_data;
					REG_BG_BLUE: bg_b <= cfg_data;
					REG_DEPTH_ENABLE: depth_on <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== sim/tb_gaussian_splat_alpha_blend.sv =====
`timescale 1ns / 1ps

module tb_gaussian_splat_alpha_blend;
	import gsab_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count, pending, pixels_seen;
	int          splats_sent;
	bit          no_idle;

	gsab_splat_if splat_in ();
	gsab_pixel_if pixel_out ();

	gaussian_splat_alpha_blend dut (
		.clk(clk), .arst_n(arst_n), .splat_in(splat_in), .pixel_out(pixel_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gsab_checker u_checker (
		.clk(clk), .arst_n(arst_n), .splat_in(splat_in), .pixel_out(pixel_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .pixels_seen(pixels_seen)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

	// pixel side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) pixel_out.ready <= 1'b0;
		else pixel_out.ready <= no_idle || ($urandom_range(99) >= 10);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] r, g, b, input logic den);
		write_reg(REG_BG_RED, r);
		write_reg(REG_BG_GREEN, g);
		write_reg(REG_BG_BLUE, b);
		write_reg(REG_DEPTH_ENABLE, {15'd0, den});
		cfg_we <= 1'b0;
	endtask

	// one splat request; valid stays high across back-to-back requests
	task automatic send_splat(input logic [11:0] px, py, input logic signed [17:0] mx, my,
		input logic [11:0] rad, input logic signed [19:0] ca, cb, cc,
		input logic [15:0] op, input logic [47:0] rgb, input logic [23:0] dep,
		input logic lst);
		while (!no_idle && $urandom_range(99) < 10) begin
			splat_in.valid <= 1'b0;
			@(posedge clk);
		end
		splat_in.valid <= 1'b1;
		splat_in.pix_x <= px; splat_in.pix_y <= py;
		splat_in.mean_x <= mx; splat_in.mean_y <= my;
		splat_in.radius <= rad;
		splat_in.conic_a <= ca; splat_in.conic_b <= cb; splat_in.conic_c <= cc;
		splat_in.opacity <= op; splat_in.color_rgb <= rgb;
		splat_in.depth <= dep; splat_in.last <= lst;
		@(posedge clk);
		while (!splat_in.ready) @(posedge clk);
		splats_sent++;
	endtask

	task automatic drain();
		splat_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// splats that make no pixel may still be in flight
		repeat (200) @(posedge clk);
	endtask

	// well-formed splat near the pixel with a gaussian that yields real alpha
	task automatic send_near(input logic [11:0] px, py, input logic lst);
		logic signed [17:0] mx, my;
		logic signed [19:0] ca, cb, cc;
		mx = 18'(int'({px, 4'd0}) + $signed($urandom_range(64)) - 32);
		my = 18'(int'({py, 4'd0}) + $signed($urandom_range(64)) - 32);
		ca = 20'($urandom_range(1 << 15));
		cc = 20'($urandom_range(1 << 15));
		cb = 20'($signed($urandom_range(1 << 14)) - (1 << 13));
		send_splat(px, py, mx, my, 12'($urandom_range(4)), ca, cb, cc,
			16'($urandom_range(65535)), {$urandom, $urandom}, 24'($urandom), lst);
	endtask

	task automatic send_noise(input logic lst);
		send_splat(12'($urandom), 12'($urandom), 18'($urandom), 18'($urandom), 12'($urandom),
			20'($urandom), 20'($urandom), 20'($urandom), 16'($urandom),
			{$urandom, $urandom}, 24'($urandom), lst);
	endtask

	task automatic random_phase(input int n);
		int count, len;
		logic [11:0] px, py;
		count = 0;
		while (count < n) begin
			px = 12'($urandom);
			py = 12'($urandom);
			len = $urandom_range(8, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) send_noise(i == len - 1);
				else send_near(px, py, i == len - 1);
				count++;
			end
		end
	endtask

	initial begin
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		splat_in.valid = 0; splat_in.pix_x = '0; splat_in.pix_y = '0;
		splat_in.mean_x = '0; splat_in.mean_y = '0; splat_in.radius = '0;
		splat_in.conic_a = '0; splat_in.conic_b = '0; splat_in.conic_c = '0;
		splat_in.opacity = '0; splat_in.color_rgb = '0; splat_in.depth = '0;
		splat_in.last = 0;
		splats_sent = 0;
		no_idle = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset defaults: black background, depth on
		// empty pixel gives background only
		send_splat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
		// dead-center opaque splat, alpha capped, max color
		send_splat(5, 5, 80, 80, 0, 0, 0, 0, 16'hFFFF, '1, 0, 0);
		send_splat(5, 5, 80, 80, 0, 0, 0, 0, 16'hFFFF, '1, 24'hFFFFFF, 1);
		// outside the box
		send_splat(12'hFFF, 12'hFFF, -18'sd131072, 18'sd131071, 12'hFFF, 0, 0, 0,
			16'hFFFF, '1, 1, 1);
		// positive power from negative conic
		send_splat(1, 1, 20, 20, 2, -20'sd524288, 0, 0, 16'hFFFF, '1, 4096, 1);
		// far tail
		send_splat(1, 1, 40, 16, 4, 20'sd524287, 20'sd524287, 20'sd524287,
			16'hFFFF, '1, 4096, 1);
		// alpha below 1/255
		send_splat(2, 2, 32, 32, 1, 0, 0, 0, 16'd200, '1, 4096, 1);
		// pixel done then ignored splats, accumulator saturation
		for (int i = 0; i < 6; i++)
			send_splat(3, 3, 48, 48, 1, 0, 0, 0, 16'hFFFF, '1, 1, 0);
		send_splat(3, 3, 48, 48, 1, 0, 0, 0, 16'hFFFF, '1, 1, 1);
		drain();

		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_splat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
		send_splat(7, 9, 112, 144, 1, 20'sd4096, -20'sd2048, 20'sd4096, 16'h8000,
			48'h8000_4000_FFFF, 24'h001000, 1);
		random_phase(400);
		drain();

		set_config(16'h1234, 16'h0000, 16'hABCD, 1'b1);
		no_idle = 1;
		random_phase(500);
		no_idle = 0;
		random_phase(400);
		drain();

		set_config(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		random_phase(600);
		drain();

		$display("sent %0d splat requests, checked %0d pixels over four background settings",
			splats_sent, pixels_seen);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d pixel mismatches", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
